/* rtl/infix_expression_evaluator_defines.svh */
// Assertion macros shared by the infix expression evaluator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define IEE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("evaluator check failed in the same cycle");

// Check that holds in the cycle after its trigger.
`define IEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("evaluator check failed one cycle later");

`endif

/* rtl/iee_pkg.sv */
// Types, codes and constants of the infix expression evaluator.
// Depends on nothing; used by the interfaces and all modules.
`default_nettype none

package iee_pkg;

    localparam int NEST_DEPTH_DEF = 8;
    localparam int VALUE_BITS_DEF = 32;
    localparam int SYMBOL_BITS    = 8;
    localparam int OUT_BITS       = 32;
    localparam int STATUS_BITS    = 3;

    // ASCII codes of the accepted characters.
    localparam logic [SYMBOL_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYMBOL_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [SYMBOL_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_BITS-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_BITS-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYMBOL_BITS-1:0] CH_LPAR  = 8'h28;
    localparam logic [SYMBOL_BITS-1:0] CH_RPAR  = 8'h29;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_DIV_ZERO = 3'd2,
        ST_BRACKET  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // Pending multiplicative operator; code 3 acts as none.
    localparam logic [1:0] MOP_NONE = 2'd0;
    localparam logic [1:0] MOP_MUL  = 2'd1;
    localparam logic [1:0] MOP_DIV  = 2'd2;

    typedef enum logic [1:0] {
        AFT_ADD,
        AFT_MUL,
        AFT_CLOSE,
        AFT_LAST
    } t_after;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FACTOR,
        S_WAIT,
        S_FACT_DONE,
        S_POP,
        S_FINISH,
        S_OUT
    } t_state;

    // Control from the sequencer to the multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctl;

endpackage

`default_nettype wire

/* rtl/iee_if.sv */
// Handshake interfaces for the symbol input and the result output.
// Depends on iee_pkg for the field widths.
`default_nettype none

interface iee_in_if;
    import iee_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   last;
    modport source (output valid, symbol, last, input ready);
    modport sink (input valid, symbol, last, output ready);
endinterface

interface iee_out_if;
    import iee_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [OUT_BITS-1:0]    value;
    logic        [STATUS_BITS-1:0] status;
    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

`default_nettype wire

/* rtl/infix_expression_evaluator.sv */
// A digit or '(' goes through the decode and finish states before the next request; + - * /
// also through the factor and fold-done states, ')' also through the pop state; a pending * or /
// is folded in the bit-serial multiply/divide unit. The final character adds one more fold and
// the output load; the result is visible the cycle after the load. A result still waiting
// in the output register stalls the next final character in its load state. Reset (synchronous)
// clears control and arithmetic state; the frame memory is not cleared, it is read after a push.
`default_nettype none

`include "infix_expression_evaluator_defines.svh"

module infix_expression_evaluator #(
    parameter int NEST_DEPTH = iee_pkg::NEST_DEPTH_DEF,
    parameter int VALUE_BITS = iee_pkg::VALUE_BITS_DEF
) (
    input wire        i_clk,
    input wire        i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out
);
    import iee_pkg::*;

    localparam int LW      = $clog2(NEST_DEPTH + 1);
    localparam int AW      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int FRAME_W = 2 * VALUE_BITS + 3;
    localparam int WX      = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;

    t_state                 r_state, n_state;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic                   r_last, n_last;
    logic [VALUE_BITS-1:0]  r_sum, n_sum;
    logic [VALUE_BITS-1:0]  r_prod, n_prod;
    logic [VALUE_BITS-1:0]  r_cur, n_cur;
    logic                   r_sign, n_sign;
    logic [1:0]             r_mop, n_mop;
    logic [LW-1:0]          r_level, n_level;
    t_status                r_err, n_err;
    t_after                 r_after, n_after;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]    r_out_value, n_out_value;
    t_status                r_out_status, n_out_status;

    // Frame stack memory and its registered read port.
    logic [FRAME_W-1:0]     mem_frames [NEST_DEPTH];
    logic [FRAME_W-1:0]     r_frame;
    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_addr;
    logic [FRAME_W-1:0]     mem_wdata;

    t_md_ctl                md_ctl;
    logic                   md_done;
    logic [VALUE_BITS-1:0]  md_result;

    logic                   is_digit;
    logic                   valid_char;
    logic [3:0]             digit;
    logic [VALUE_BITS-1:0]  sum_new;
    logic [LW-1:0]          level_dec;
    logic [WX-1:0]          sum_wide;

    iee_muldiv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (md_ctl),
        .i_a      (r_prod),
        .i_b      (r_cur),
        .o_done   (md_done),
        .o_result (md_result)
    );

    // Character classification.
    assign is_digit   = (r_sym >= CH_ZERO) && (r_sym <= CH_NINE);
    assign valid_char = is_digit || (r_sym == CH_PLUS) || (r_sym == CH_MINUS) ||
                        (r_sym == CH_STAR) || (r_sym == CH_SLASH) ||
                        (r_sym == CH_LPAR) || (r_sym == CH_RPAR);
    assign digit      = r_sym[3:0];
    assign sum_new    = r_sign ? (r_sum - r_prod) : (r_sum + r_prod);
    assign level_dec  = r_level - 1'b1;
    assign sum_wide   = WX'(r_sum);

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state      = r_state;
        n_sym        = r_sym;
        n_last       = r_last;
        n_sum        = r_sum;
        n_prod       = r_prod;
        n_cur        = r_cur;
        n_sign       = r_sign;
        n_mop        = r_mop;
        n_level      = r_level;
        n_err        = r_err;
        n_after      = r_after;
        n_out_valid  = r_out_valid & ~o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_level[AW-1:0];
        mem_wdata    = {r_sum, r_prod, r_mop, r_sign};
        md_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sym   = i_in.symbol;
                    n_last  = i_in.last;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if (!valid_char) begin
                    n_err = ST_BAD_CHAR;
                end else if (r_err == ST_OK) begin
                    if (is_digit) begin
                        n_cur = (r_cur << 3) + (r_cur << 1) + VALUE_BITS'(digit);
                    end else begin
                        case (r_sym) inside
                            CH_PLUS, CH_MINUS: begin
                                n_after = AFT_ADD;
                                n_state = S_FACTOR;
                            end
                            CH_STAR, CH_SLASH: begin
                                n_after = AFT_MUL;
                                n_state = S_FACTOR;
                            end
                            CH_LPAR: begin
                                if (r_level >= LW'(NEST_DEPTH)) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    mem_we  = 1'b1;
                                    n_level = r_level + 1'b1;
                                    n_sum   = '0;
                                    n_prod  = '0;
                                    n_cur   = '0;
                                    n_sign  = 1'b0;
                                    n_mop   = MOP_NONE;
                                end
                            end
                            default: begin
                                if (r_level == '0) begin
                                    n_err = ST_BRACKET;
                                end else begin
                                    n_after = AFT_CLOSE;
                                    n_state = S_FACTOR;
                                end
                            end
                        endcase
                    end
                end
            end
            S_FACTOR: begin
                n_state = S_FACT_DONE;
                n_cur   = '0;
                n_mop   = MOP_NONE;
                if (r_mop == MOP_MUL) begin
                    md_ctl.start  = 1'b1;
                    md_ctl.is_div = 1'b0;
                    n_cur         = r_cur;
                    n_mop         = r_mop;
                    n_state       = S_WAIT;
                end else if (r_mop == MOP_DIV) begin
                    if (r_cur == '0) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_DIV_ZERO;
                        end
                        n_prod = '0;
                    end else begin
                        md_ctl.start  = 1'b1;
                        md_ctl.is_div = 1'b1;
                        n_cur         = r_cur;
                        n_mop         = r_mop;
                        n_state       = S_WAIT;
                    end
                end else begin
                    n_prod = r_cur;
                end
            end
            S_WAIT: begin
                if (md_done) begin
                    n_prod  = md_result;
                    n_cur   = '0;
                    n_mop   = MOP_NONE;
                    n_state = S_FACT_DONE;
                end
            end
            S_FACT_DONE: begin
                unique case (r_after)
                    AFT_MUL: begin
                        n_mop   = (r_sym == CH_STAR) ? MOP_MUL : MOP_DIV;
                        n_state = S_FINISH;
                    end
                    AFT_ADD: begin
                        n_sum   = sum_new;
                        n_prod  = '0;
                        n_sign  = (r_sym == CH_MINUS);
                        n_state = S_FINISH;
                    end
                    AFT_CLOSE: begin
                        n_cur    = sum_new;
                        n_prod   = '0;
                        n_sign   = 1'b0;
                        mem_re   = 1'b1;
                        mem_addr = level_dec[AW-1:0];
                        n_level  = level_dec;
                        n_state  = S_POP;
                    end
                    default: begin
                        n_sum  = sum_new;
                        n_prod = '0;
                        n_sign = 1'b0;
                        if ((r_level != '0) && (r_err == ST_OK)) begin
                            n_err = ST_BRACKET;
                        end
                        n_state = S_OUT;
                    end
                endcase
            end
            S_POP: begin
                n_sum   = r_frame[FRAME_W-1 -: VALUE_BITS];
                n_prod  = r_frame[VALUE_BITS+2:3];
                n_mop   = r_frame[2:1];
                n_sign  = r_frame[0];
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_err == ST_OK) begin
                    n_after = AFT_LAST;
                    n_state = S_FACTOR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_err == ST_OK) ? sum_wide[OUT_BITS-1:0] : '0;
                    n_out_status = r_err;
                    n_sum        = '0;
                    n_prod       = '0;
                    n_cur        = '0;
                    n_sign       = 1'b0;
                    n_mop        = MOP_NONE;
                    n_level      = '0;
                    n_err        = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_sum       <= '0;
            r_prod      <= '0;
            r_cur       <= '0;
            r_sign      <= 1'b0;
            r_mop       <= MOP_NONE;
            r_level     <= '0;
            r_err       <= ST_OK;
            r_after     <= AFT_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_sum       <= n_sum;
            r_prod      <= n_prod;
            r_cur       <= n_cur;
            r_sign      <= n_sign;
            r_mop       <= n_mop;
            r_level     <= n_level;
            r_err       <= n_err;
            r_after     <= n_after;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Frame stack memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_frames[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_frame <= mem_frames[mem_addr];
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    // Checks on the sequencer.
    `IEE_ASSERT_SAME(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= LW'(NEST_DEPTH))
    `IEE_ASSERT_NEXT(a_wait_done, i_clk, i_rst_n, (r_state == S_WAIT) && md_done, r_state == S_FACT_DONE)
    `IEE_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_OK), r_out_value == '0)
    `IEE_ASSERT_NEXT(a_pop_follows, i_clk, i_rst_n, mem_re, r_state == S_POP)

endmodule

`default_nettype wire

/* rtl/iee_muldiv.sv */
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Depends on iee_pkg for the control struct.
`default_nettype none

module iee_muldiv #(
    parameter int VALUE_BITS = iee_pkg::VALUE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  var iee_pkg::t_md_ctl   i_ctl,
    input  wire [VALUE_BITS-1:0]   i_a,
    input  wire [VALUE_BITS-1:0]   i_b,
    output logic                   o_done,
    output logic [VALUE_BITS-1:0]  o_result
);
    import iee_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic                  r_div;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] r_x;
    logic [VALUE_BITS-1:0] r_y;

    logic [VALUE_BITS:0]   rem;
    logic [VALUE_BITS:0]   diff;

    // Partial remainder with the next dividend bit, and its trial subtract.
    assign rem  = {r_acc, r_x[VALUE_BITS-1]};
    assign diff = rem - {1'b0, r_y};

    // Control: bit counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands are loaded as magnitudes for a divide.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div <= i_ctl.is_div;
            r_acc <= '0;
            if (i_ctl.is_div) begin
                r_neg <= i_a[VALUE_BITS-1] ^ i_b[VALUE_BITS-1];
                r_x   <= i_a[VALUE_BITS-1] ? -i_a : i_a;
                r_y   <= i_b[VALUE_BITS-1] ? -i_b : i_b;
            end else begin
                r_neg <= 1'b0;
                r_x   <= i_a;
                r_y   <= i_b;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!diff[VALUE_BITS]) begin
                    r_acc <= diff[VALUE_BITS-1:0];
                    r_x   <= {r_x[VALUE_BITS-2:0], 1'b1};
                end else begin
                    r_acc <= rem[VALUE_BITS-1:0];
                    r_x   <= {r_x[VALUE_BITS-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[VALUE_BITS-2:0], 1'b0};
                r_y <= {1'b0, r_y[VALUE_BITS-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? -r_x : r_x) : r_acc;

endmodule

`default_nettype wire
